FILE: sv/cab_pkg.sv
// ----------------------------------------------------------------------------
// cab_pkg
// shared types, opcodes and constants for the vector angle block
// ----------------------------------------------------------------------------
`default_nettype none

package cab_pkg;

  typedef struct packed {
    logic signed [15:0] query_elem;
    logic signed [15:0] target_elem;
    logic               last_elem;
  } cab_in_t;

  typedef struct packed {
    logic [15:0] angle_deg;
    logic        zero_norm;
    logic        too_long;
  } cab_out_t;

  // final sums of one vector pair, handed from the accumulator to the datapath
  typedef struct packed {
    logic [63:0] qsum;
    logic [63:0] tsum;
    logic [63:0] abs_dot;
    logic        dot_neg;
    logic        zero;
    logic        too_long;
  } cab_sum_t;

  localparam int CORDIC_STEPS = 23;

  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_MULP   = 4'd2;
  localparam logic [3:0] OP_NORM   = 4'd3;
  localparam logic [3:0] OP_MULX   = 4'd4;
  localparam logic [3:0] OP_SUB    = 4'd5;
  localparam logic [3:0] OP_SQRT   = 4'd6;
  localparam logic [3:0] OP_SCALE  = 4'd7;
  localparam logic [3:0] OP_CINIT  = 4'd8;
  localparam logic [3:0] OP_CORDIC = 4'd9;
  localparam logic [3:0] OP_FIN    = 4'd10;

  typedef struct packed {
    logic [3:0] op;
    logic [5:0] step;
    logic       emit;
  } cab_cmd_t;

  typedef struct packed {
    logic zero;
    logic p_top_zero;
    logic big;
  } cab_sts_t;

  // angle unit is 2^-16 degree; ANGLE_MAX is in 2^-8 degree (q8.8)
  localparam logic signed [24:0] DEG90_UNITS  = 25'sd5898240;
  localparam logic signed [24:0] DEG180_UNITS = 25'sd11796480;
  localparam logic [16:0]        ANGLE_MAX    = 17'd46080;

  // atan(2^-i) in degrees, unit 2^-16 degree
  function automatic logic signed [24:0] cab_atan(input logic [4:0] idx);
    logic signed [24:0] v;
    case (idx)
      5'd0:    v = 25'sd2949120;
      5'd1:    v = 25'sd1740967;
      5'd2:    v = 25'sd919879;
      5'd3:    v = 25'sd466945;
      5'd4:    v = 25'sd234379;
      5'd5:    v = 25'sd117304;
      5'd6:    v = 25'sd58666;
      5'd7:    v = 25'sd29335;
      5'd8:    v = 25'sd14668;
      5'd9:    v = 25'sd7334;
      5'd10:   v = 25'sd3667;
      5'd11:   v = 25'sd1833;
      5'd12:   v = 25'sd917;
      5'd13:   v = 25'sd458;
      5'd14:   v = 25'sd229;
      5'd15:   v = 25'sd115;
      5'd16:   v = 25'sd57;
      5'd17:   v = 25'sd29;
      5'd18:   v = 25'sd14;
      5'd19:   v = 25'sd7;
      5'd20:   v = 25'sd4;
      5'd21:   v = 25'sd2;
      5'd22:   v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/cab_accum.sv
// ----------------------------------------------------------------------------
// cab_accum
// running dot product and sums of squares, one pair per cycle when taken
// ----------------------------------------------------------------------------
`default_nettype none

module cab_accum import cab_pkg::*; #(
  parameter int MAX_DIM   = 1024,
  parameter int ELEM_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     take,
  input  wire cab_in_t  elem,
  output cab_sum_t      sums
);

  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int PROD_W = 2 * ELEM_BITS;
  localparam int ACC_W  = PROD_W + CNT_W;

  logic signed [ELEM_BITS-1:0] qv, tv;
  logic signed [PROD_W-1:0]    qt, qq, tt;
  logic signed [ACC_W-1:0]     dot_r, dot_nxt, abs_dot;
  logic [ACC_W-1:0]            qs_r, qs_nxt, ts_r, ts_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        ovf_r, ovf_nxt, room;

  // low ELEM_BITS of the field; bits above the 16-bit field read as zero
  always_comb begin
    for (int i = 0; i < ELEM_BITS; i++) begin
      qv[i] = (i < 16) ? elem.query_elem[i % 16] : 1'b0;
      tv[i] = (i < 16) ? elem.target_elem[i % 16] : 1'b0;
    end
  end

  assign qt   = qv * tv;
  assign qq   = qv * qv;
  assign tt   = tv * tv;
  assign room = (cnt_r < CNT_W'(MAX_DIM));

  always_comb begin
    dot_nxt = dot_r;
    qs_nxt  = qs_r;
    ts_nxt  = ts_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (room) begin
      dot_nxt = dot_r + ACC_W'(qt);
      qs_nxt  = qs_r + ACC_W'($unsigned(qq));
      ts_nxt  = ts_r + ACC_W'($unsigned(tt));
      cnt_nxt = cnt_r + CNT_W'(1);
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  assign abs_dot       = dot_nxt[ACC_W-1] ? -dot_nxt : dot_nxt;
  assign sums.qsum     = 64'(qs_nxt);
  assign sums.tsum     = 64'(ts_nxt);
  assign sums.abs_dot  = 64'($unsigned(abs_dot));
  assign sums.dot_neg  = dot_nxt[ACC_W-1];
  assign sums.zero     = (qs_nxt == '0) || (ts_nxt == '0);
  assign sums.too_long = ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      qs_r  <= '0;
      ts_r  <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (take) begin
      if (elem.last_elem) begin
        dot_r <= '0;
        qs_r  <= '0;
        ts_r  <= '0;
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        dot_r <= dot_nxt;
        qs_r  <= qs_nxt;
        ts_r  <= ts_nxt;
        cnt_r <= cnt_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/cab_ctrl.sv
// ----------------------------------------------------------------------------
// cab_ctrl
// sequencer for the angle finish: multiply, normalize, root, cordic
// ----------------------------------------------------------------------------
`default_nettype none

module cab_ctrl import cab_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_take,
  input  wire logic     in_last,
  input  wire logic     out_free,
  input  wire cab_sts_t sts,
  output cab_cmd_t      cmd,
  output logic          busy
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_MULP   = 4'd2;
  localparam logic [3:0] S_NORM   = 4'd3;
  localparam logic [3:0] S_MULX   = 4'd4;
  localparam logic [3:0] S_SUB    = 4'd5;
  localparam logic [3:0] S_SQRT   = 4'd6;
  localparam logic [3:0] S_SCALE  = 4'd7;
  localparam logic [3:0] S_CINIT  = 4'd8;
  localparam logic [3:0] S_CORDIC = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;
  localparam logic [3:0] S_RESULT = 4'd11;

  localparam logic [5:0] STEP_LAST_MUL  = 6'd3;
  localparam logic [5:0] STEP_LAST_BIT  = 6'd63;
  localparam logic [5:0] STEP_LAST_ROT  = 6'(CORDIC_STEPS - 1);

  logic [3:0] state_r, state_nxt;
  logic [5:0] step_r, step_nxt;

  assign busy     = (state_r != S_IDLE);
  assign cmd.step = step_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd.op    = OP_NONE;
    cmd.emit  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_take && in_last) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        step_nxt  = '0;
        state_nxt = sts.zero ? S_FIN : S_MULP;
      end
      S_MULP: begin
        cmd.op = OP_MULP;
        if (step_r == STEP_LAST_MUL) begin
          step_nxt  = '0;
          state_nxt = S_NORM;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      S_NORM: begin
        if (!sts.p_top_zero || step_r == STEP_LAST_BIT) begin
          step_nxt  = '0;
          state_nxt = S_MULX;
        end else begin
          cmd.op   = OP_NORM;
          step_nxt = step_r + 6'd1;
        end
      end
      S_MULX: begin
        cmd.op = OP_MULX;
        if (step_r == STEP_LAST_MUL) begin
          state_nxt = S_SUB;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      S_SUB: begin
        cmd.op    = OP_SUB;
        step_nxt  = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (step_r == STEP_LAST_BIT) begin
          state_nxt = S_SCALE;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      S_SCALE: begin
        if (sts.big) begin
          cmd.op = OP_SCALE;
        end else begin
          state_nxt = S_CINIT;
        end
      end
      S_CINIT: begin
        cmd.op    = OP_CINIT;
        step_nxt  = '0;
        state_nxt = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.op = OP_CORDIC;
        if (step_r == STEP_LAST_ROT) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      S_FIN: begin
        cmd.op    = OP_FIN;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cab_dpath.sv
// ----------------------------------------------------------------------------
// cab_dpath
// finish datapath: 32x32 multiplier, bit-serial root, shift-add cordic
// ----------------------------------------------------------------------------
`default_nettype none

module cab_dpath import cab_pkg::*; (
  input  wire logic     clk,
  input  wire cab_sum_t sums,
  input  wire cab_cmd_t cmd,
  output cab_sts_t      sts,
  output cab_out_t      res
);

  logic [63:0]         qs_r, ts_r, x_r, y_r;
  logic [127:0]        p_r, rad_r;
  logic [66:0]         rem_r;
  logic signed [33:0]  cx_r, cy_r;
  logic signed [24:0]  z_r;
  logic                neg_r, zero_r, tl_r;
  logic [15:0]         ang_r;

  // multiplier: one 32x32 partial product per step
  logic [63:0]  mul_a, mul_b, pp;
  logic [31:0]  a_part, b_part;
  logic [127:0] pp_sh, mul_acc, mul_sum;

  assign mul_a   = (cmd.op == OP_MULP) ? qs_r : x_r;
  assign mul_b   = (cmd.op == OP_MULP) ? ts_r : x_r;
  assign a_part  = cmd.step[1] ? mul_a[63:32] : mul_a[31:0];
  assign b_part  = cmd.step[0] ? mul_b[63:32] : mul_b[31:0];
  assign pp      = a_part * b_part;
  assign mul_acc = (cmd.step[1:0] == 2'd0) ? 128'd0 :
                   ((cmd.op == OP_MULP) ? p_r : rad_r);

  always_comb begin
    case ({cmd.step[1], cmd.step[0]})
      2'b00:   pp_sh = {64'd0, pp};
      2'b11:   pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  assign mul_sum = mul_acc + pp_sh;

  // root digit step
  logic [66:0] rem_sh, trial;
  logic        fits;

  assign rem_sh = {rem_r[64:0], rad_r[127:126]};
  assign trial  = {1'b0, y_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  // cordic rotation
  function automatic logic signed [33:0] shr_sym(input logic signed [33:0] v,
                                                 input logic [4:0] sh);
    logic [33:0] mag, m;
    mag = v[33] ? 34'(-v) : 34'(v);
    m   = mag >> sh;
    return v[33] ? -$signed(m) : $signed(m);
  endfunction

  logic signed [33:0] sx, sy;
  logic signed [24:0] atan_v;

  assign sx     = shr_sym(cx_r, cmd.step[4:0]);
  assign sy     = shr_sym(cy_r, cmd.step[4:0]);
  assign atan_v = cab_atan(cmd.step[4:0]);

  // final angle
  logic signed [24:0] zc, theta;
  logic [24:0]        theta_rnd;
  logic [16:0]        ang_full;

  always_comb begin
    if (z_r < 0)                zc = '0;
    else if (z_r > DEG90_UNITS) zc = DEG90_UNITS;
    else                        zc = z_r;
    theta     = neg_r ? (DEG180_UNITS - zc) : zc;
    theta_rnd = $unsigned(theta) + 25'd128;
    ang_full  = theta_rnd[24:8];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        qs_r   <= sums.qsum;
        ts_r   <= sums.tsum;
        x_r    <= sums.abs_dot;
        neg_r  <= sums.dot_neg;
        zero_r <= sums.zero;
        tl_r   <= sums.too_long;
      end
      OP_MULP: p_r   <= mul_sum;
      OP_MULX: rad_r <= mul_sum;
      OP_NORM: begin
        p_r <= {p_r[125:0], 2'b00};
        x_r <= {x_r[62:0], 1'b0};
      end
      OP_SUB: begin
        rad_r <= (p_r < rad_r) ? 128'd0 : (p_r - rad_r);
        rem_r <= '0;
        y_r   <= '0;
      end
      OP_SQRT: begin
        rad_r <= {rad_r[125:0], 2'b00};
        rem_r <= fits ? (rem_sh - trial) : rem_sh;
        y_r   <= {y_r[62:0], fits};
      end
      OP_SCALE: begin
        x_r <= {1'b0, x_r[63:1]};
        y_r <= {1'b0, y_r[63:1]};
      end
      OP_CINIT: begin
        cx_r <= $signed({4'd0, x_r[29:0]});
        cy_r <= $signed({4'd0, y_r[29:0]});
        z_r  <= '0;
      end
      OP_CORDIC: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + sy;
          cy_r <= cy_r - sx;
          z_r  <= z_r + atan_v;
        end else begin
          cx_r <= cx_r - sy;
          cy_r <= cy_r + sx;
          z_r  <= z_r - atan_v;
        end
      end
      OP_FIN: begin
        if (zero_r)                 ang_r <= '0;
        else if (ang_full > ANGLE_MAX) ang_r <= ANGLE_MAX[15:0];
        else                        ang_r <= ang_full[15:0];
      end
      default: begin
      end
    endcase
  end

  assign sts.zero       = zero_r;
  assign sts.p_top_zero = (p_r[127:124] == 4'd0);
  assign sts.big        = (x_r[63:30] != '0) || (y_r[63:30] != '0);

  assign res.angle_deg = ang_r;
  assign res.zero_norm = zero_r;
  assign res.too_long  = tl_r;

endmodule

`default_nettype wire

FILE: sv/cosine_angle_between_vectors.sv
// ----------------------------------------------------------------------------
// cosine_angle_between_vectors
// angle in degrees (q8.8) between two streamed vectors
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake           word
//   in_      in   in_valid/in_stall   query_elem, target_elem, last_elem
//   out_     out  out_valid/out_stall angle_deg, zero_norm, too_long
//
// element words are taken one per cycle into the accumulators unless stalled
// after the last word of a pair the finish sequencer runs and holds in_stall:
//   load, check, multiply, up to 63 normalize steps, multiply, subtract,
//   one-bit-per-cycle square root, up to 34 scale steps, the 23-step cordic
//   and the final angle, then it waits while out_stall holds the last result
// a zero-norm pair skips from the check straight to the final angle
// the result sits in an output register; out_stall delays its release
// reset (rst_n low, synchronous) clears accumulators, sequencer and out_valid
//
`default_nettype none

module cosine_angle_between_vectors import cab_pkg::*; #(
  parameter int MAX_DIM   = 1024,
  parameter int ELEM_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire cab_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output cab_out_t      out_data
);

  logic     in_take, out_free, busy;
  cab_sum_t sums;
  cab_cmd_t cmd;
  cab_sts_t sts;
  cab_out_t res;
  logic     out_valid_r;
  cab_out_t out_data_r;

  // no element words while a pair is being finished
  assign in_stall = busy;
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  cab_accum #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (in_take),
    .elem  (in_data),
    .sums  (sums)
  );

  cab_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .in_last  (in_data.last_elem),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  cab_dpath u_dpath (
    .clk  (clk),
    .sums (sums),
    .cmd  (cmd),
    .sts  (sts),
    .res  (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: sv/cab_checker.sv
// ----------------------------------------------------------------------------
// cab_checker
// port-level checks for the vector angle block
// ----------------------------------------------------------------------------
`default_nettype none

module cab_checker import cab_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire cab_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire cab_out_t out_data
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // last word starts the finish, which blocks the input
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_elem |=> in_stall)
    else $error("input not stalled after last word");

  // zero norm always reports angle zero
  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_norm |-> out_data.angle_deg == 16'd0)
    else $error("zero norm with nonzero angle");

  // angle never above 180 degrees
  a_angle_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.angle_deg <= ANGLE_MAX[15:0])
    else $error("angle above 180 degrees");

endmodule

bind cosine_angle_between_vectors cab_checker u_cab_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: verif/tb_cosine_angle_between_vectors.sv
// ----------------------------------------------------------------------------
// tb_cosine_angle_between_vectors
// streams vector pairs into the angle block and checks every result word
// against an integer cordic predictor kept inside the testbench
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_cosine_angle_between_vectors;
  import cab_pkg::*;

  localparam int DIM_LIMIT  = 1024;
  localparam int IDLE_LIMIT = 5000;  // cycles with no word moving on either side
  localparam int HOLD_LEN   = 400;

  // atan(2^-i) in units of 2^-16 degree
  localparam int ATAN_UNITS [23] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  cab_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cab_out_t out_data;

  // gap/stall control: quiet turns off all idling, hold_req asks for a long receiver hold
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit failed = 1'b0;
  int words_sent = 0;

  // predicted angle words, oldest first
  cab_out_t angle_q[$];

  // running sums of the pair being streamed
  logic signed [63:0] dot_acc = '0;
  logic [63:0]        q_energy = '0;
  logic [63:0]        t_energy = '0;
  int                 elem_cnt = 0;
  bit                 dim_overrun = 1'b0;

  cosine_angle_between_vectors dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // arithmetic shift that rounds toward zero, as the cordic expects
  function automatic logic signed [63:0] shift_mag(input logic signed [63:0] v, input int s);
    logic [63:0] m;
    if (v < 0) begin
      m = -v;
      return -$signed(m >> s);
    end
    return $signed($unsigned(v) >> s);
  endfunction

  // angle in q8.8 degrees from dot product and the two energies (both nonzero)
  function automatic logic [15:0] angle_from_sums(input logic signed [63:0] d,
                                                  input logic [63:0] qe, te);
    logic [127:0] p, dd, sq;
    logic [63:0] ad, x, y, bg, tr;
    logic signed [63:0] cx, cy, nx, ny, z, th;
    int k, s, b;
    ad = (d < 0) ? -d : d;
    p = {64'd0, qe} * {64'd0, te};
    k = 0;
    // normalize the product so the square root keeps its precision
    while (k < 63 && p[127:124] == 4'd0) begin
      p = p << 2;
      k++;
    end
    x = ad << k;
    sq = {64'd0, x} * {64'd0, x};
    dd = (p < sq) ? 128'd0 : p - sq;
    y = '0;
    for (b = 63; b >= 0; b--) begin
      tr = y | (64'd1 << b);
      if (!(dd < {64'd0, tr} * {64'd0, tr})) y = tr;
    end
    bg = (x > y) ? x : y;
    s = 0;
    while (s < 63 && (bg >> s) >= (64'd1 << 30)) s++;
    cx = $signed(x >> s);
    cy = $signed(y >> s);
    z = 0;
    for (int i = 0; i < 23; i++) begin
      if (cy > 0) begin
        nx = cx + shift_mag(cy, i);
        ny = cy - shift_mag(cx, i);
        z += ATAN_UNITS[i];
      end else begin
        nx = cx - shift_mag(cy, i);
        ny = cy + shift_mag(cx, i);
        z -= ATAN_UNITS[i];
      end
      cx = nx;
      cy = ny;
    end
    if (z < 0) z = 0;
    if (z > 5898240) z = 5898240;
    th = (d < 0) ? 64'sd11796480 - z : z;
    th = (th + 128) >>> 8;
    if (th > 46080) th = 46080;
    return th[15:0];
  endfunction

  // accumulate one accepted word, push the expected angle word on a last mark
  task automatic accumulate_word(input cab_in_t w);
    logic signed [63:0] qv, tv;
    cab_out_t r;
    qv = w.query_elem;
    tv = w.target_elem;
    if (elem_cnt < DIM_LIMIT) begin
      dot_acc  += qv * tv;
      q_energy += qv * qv;
      t_energy += tv * tv;
      elem_cnt++;
    end else begin
      dim_overrun = 1'b1;
    end
    if (w.last_elem) begin
      if (q_energy == 0 || t_energy == 0) begin
        r.angle_deg = '0;
        r.zero_norm = 1'b1;
      end else begin
        r.angle_deg = angle_from_sums(dot_acc, q_energy, t_energy);
        r.zero_norm = 1'b0;
      end
      r.too_long = dim_overrun;
      angle_q.push_back(r);
      dot_acc = '0;
      q_energy = '0;
      t_energy = '0;
      elem_cnt = 0;
      dim_overrun = 1'b0;
    end
  endtask

  // input monitor: sample at the rising edge where a word is taken
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) accumulate_word(in_data);
  end

  // result checker: compare each released word with the oldest prediction
  always @(posedge clk) begin
    cab_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (angle_q.size() == 0) begin
        $display("%0t: unexpected result word angle=%0d zero_norm=%0b too_long=%0b",
                 $time, out_data.angle_deg, out_data.zero_norm, out_data.too_long);
        failed = 1'b1;
      end else begin
        e = angle_q.pop_front();
        if (out_data.angle_deg !== e.angle_deg) begin
          $display("%0t: angle_deg expected %0d got %0d", $time, e.angle_deg,
                   out_data.angle_deg);
          failed = 1'b1;
        end
        if (out_data.zero_norm !== e.zero_norm) begin
          $display("%0t: zero_norm expected %0b got %0b", $time, e.zero_norm,
                   out_data.zero_norm);
          failed = 1'b1;
        end
        if (out_data.too_long !== e.too_long) begin
          $display("%0t: too_long expected %0b got %0b", $time, e.too_long,
                   out_data.too_long);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog: counts cycles in which no word moves on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall bursts, plus one long hold when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rst_n && !quiet && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // offer one word, with an occasional gap first; returns once it is taken
  task automatic send_word(input logic signed [15:0] q, t, input logic last);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_data <= '{query_elem: q, target_elem: t, last_elem: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // a pair of n equal-valued components
  task automatic send_flat(input int n, input logic signed [15:0] q, t);
    for (int i = 0; i < n; i++) send_word(q, t, i == n - 1);
  endtask

  // field extremes, parallel and antiparallel, orthogonal
  task automatic test_extremes();
    send_flat(1, -16'sd32768, -16'sd32768);
    send_flat(1, 16'sd32767, -16'sd32768);
    send_flat(1, -16'sd32768, 16'sd32767);
    send_flat(3, 16'sd32767, 16'sd32767);
    send_word(16'sd1, 16'sd0, 1'b0);
    send_word(16'sd0, 16'sd1, 1'b1);
    send_word(16'sd3, 16'sd4, 1'b0);
    send_word(-16'sd4, 16'sd3, 1'b1);
    send_word(16'sd1, 16'sd1, 1'b0);
    send_word(16'sd1, -16'sd1, 1'b1);
  endtask

  // either vector all zero
  task automatic test_zero_norm();
    send_flat(2, 16'sd0, 16'sd5);
    send_flat(1, -16'sd7, 16'sd0);
    send_flat(1, 16'sd0, 16'sd0);
  endtask

  // one past the dimension limit: the last-marked extra component is dropped
  task automatic test_dim_limit();
    for (int i = 0; i <= DIM_LIMIT; i++)
      send_word(16'($urandom), 16'($urandom), i == DIM_LIMIT);
  endtask

  // receiver holds off while the sender keeps offering pairs
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int p = 0; p < 6; p++) send_flat(2, 16'($urandom), 16'($urandom));
  endtask

  // one random pair: full range, small, (anti)parallel, near-parallel, zero or shifted
  task automatic send_random_pair();
    int n, kind;
    logic signed [15:0] q, t;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 8);
    kind = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) begin
      q = 16'($urandom);
      t = 16'($urandom);
      case (kind)
        0, 1, 2, 3: ;
        4: begin
          q = 16'($urandom_range(0, 15)) - 16'sd8;
          t = 16'($urandom_range(0, 15)) - 16'sd8;
        end
        5: t = q;
        6: t = (q == -16'sd32768) ? 16'sd32767 : -q;
        7: t = q + 16'($urandom_range(0, 6)) - 16'sd3;
        8: if ($urandom_range(0, 1)) q = 0; else t = 0;
        default: begin q = q >>> $urandom_range(0, 14); t = t >>> $urandom_range(0, 14); end
      endcase
      send_word(q, t, i == n - 1);
    end
  endtask

  task automatic test_random(input int target_words);
    while (words_sent < target_words) send_random_pair();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_zero_norm();
    test_backpressure();
    test_random(words_sent + 600);
    test_dim_limit();
    // last part runs with no idling on either side
    quiet = 1'b1;
    test_random(words_sent + 250);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (angle_q.size() == 0);
    repeat (300) @(posedge clk);
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
